// ===== sv/avwm_pkg.sv =====
// ----------------------------------------------------------------------------
// avwm_pkg
// Shared types and constants for the amplifier volume I2C write master.
// ----------------------------------------------------------------------------
package avwm_pkg;

  // Command codes on action_i
  localparam logic [1:0] ACT_VOLUME = 2'd0;
  localparam logic [1:0] ACT_MUTE   = 2'd1;
  localparam logic [1:0] ACT_RAW    = 2'd2;

  // Bus symbol codes
  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_e;

  localparam logic [7:0] VOL_REG       = 8'h02;
  localparam logic [7:0] VOL_MAX       = 8'd63;
  localparam logic [7:0] VOL_MUTEFLOOR = 8'd1;
  localparam logic [7:0] MUTE_BOTH     = 8'hC0;
  localparam logic [7:0] DEV_ADDR_RST  = 8'hC0;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Frame layout: three bytes, eight bits plus an ack slot each
  localparam logic [1:0] LAST_BYTE = 2'd2;
  localparam logic [3:0] ACK_SLOT  = 4'd8;

  // One queued frame: register byte and data byte
  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
  } frame_t;

endpackage

// ===== sv/avwm_front.sv =====
// ----------------------------------------------------------------------------
// avwm_front
// Classifies commands, keeps the stored volume word and builds frame words.
// ----------------------------------------------------------------------------
module avwm_front import avwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] volume_request_i,
  input  logic       mute_on_i,
  input  logic [7:0] reg_address_i,
  input  logic [7:0] reg_data_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output frame_t     q_frame_o
);

  logic [7:0] volume_word_q, volume_word_d;
  logic [7:0] vol_clamped;
  logic       accept;
  logic       keep;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (volume_request_i > VOL_MAX) begin
      vol_clamped = VOL_MAX;
    end else if (volume_request_i <= VOL_MUTEFLOOR) begin
      vol_clamped = MUTE_BOTH;
    end else begin
      vol_clamped = volume_request_i;
    end
  end

  always_comb begin
    keep          = 1'b1;
    volume_word_d = volume_word_q;
    q_frame_o     = '{reg_addr: VOL_REG, reg_data: volume_word_q};
    case (action_i)
      ACT_VOLUME: begin
        q_frame_o.reg_data = vol_clamped;
        if (accept) begin
          volume_word_d = vol_clamped;
        end
      end
      ACT_MUTE: begin
        if (mute_on_i) begin
          q_frame_o.reg_data = volume_word_q | MUTE_BOTH;
        end
      end
      ACT_RAW: begin
        q_frame_o = '{reg_addr: reg_address_i, reg_data: reg_data_i};
      end
      default: begin
        // drop the unused code
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_word_q <= '0;
    end else begin
      volume_word_q <= volume_word_d;
    end
  end

endmodule

// ===== sv/avwm_fifo.sv =====
// ----------------------------------------------------------------------------
// avwm_fifo
// Short frame queue that decouples command intake from the bus serializer.
// ----------------------------------------------------------------------------
module avwm_fifo import avwm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_frame_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t head_o
);

  frame_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("frame queue underflow");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("frame queue count out of range");

endmodule

// ===== sv/avwm_back.sv =====
// ----------------------------------------------------------------------------
// avwm_back
// Serializes one queued frame into 29 bus symbols through an output register.
// ----------------------------------------------------------------------------
module avwm_back import avwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] dev_addr_i,
  input  logic       q_valid_i,
  input  frame_t     q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] symbol_o,
  output logic       sda_level_o,
  output logic       last_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] byte_q, byte_d;
  logic [3:0] bit_q, bit_d;
  frame_t     frame_q, frame_d;

  logic       out_valid_q, out_valid_d;
  sym_e       sym_q, sym_d;
  logic       sda_q, sda_d;
  logic       last_q, last_d;

  logic       adv;
  logic [7:0] cur_byte;

  // advance when the output register is empty or being taken
  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    case (byte_q)
      2'd1:    cur_byte = frame_q.reg_addr;
      2'd2:    cur_byte = frame_q.reg_data;
      default: cur_byte = dev_addr_i;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    byte_d      = byte_q;
    bit_d       = bit_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q;
    sym_d       = sym_q;
    sda_d       = sda_q;
    last_d      = last_q;
    q_pop_o     = 1'b0;
    if (adv) begin
      out_valid_d = (phase_q != PH_IDLE);
      last_d      = 1'b0;
      case (phase_q)
        PH_IDLE: begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            frame_d = q_head_i;
            phase_d = PH_START;
          end
        end
        PH_START: begin
          sym_d   = SYM_START;
          sda_d   = 1'b0;
          phase_d = PH_DATA;
          byte_d  = '0;
          bit_d   = '0;
        end
        PH_DATA: begin
          if (bit_q == ACK_SLOT) begin
            sym_d = SYM_ACK;
            sda_d = 1'b1;
            bit_d = '0;
            if (byte_q == LAST_BYTE) begin
              phase_d = PH_STOP;
            end else begin
              byte_d = byte_q + 1'b1;
            end
          end else begin
            sym_d = SYM_BIT;
            sda_d = cur_byte[3'd7 - bit_q[2:0]];
            bit_d = bit_q + 1'b1;
          end
        end
        PH_STOP: begin
          sym_d  = SYM_STOP;
          sda_d  = 1'b1;
          last_d = 1'b1;
          // chain straight into the next queued frame
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            frame_d = q_head_i;
            phase_d = PH_START;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      byte_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_q      <= byte_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    sym_q   <= sym_d;
    sda_q   <= sda_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign sda_level_o = sda_q;
  assign last_o      = last_q;

  a_last_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (sym_q == SYM_STOP))
    else $error("last flag on a symbol other than stop");

  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> ((bit_q <= ACK_SLOT) && (byte_q <= LAST_BYTE)))
    else $error("bit or byte counter out of range");

  a_start_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && adv) |=> (phase_q == PH_START))
    else $error("popped frame did not enter start phase");

endmodule

// ===== sv/amp_volume_i2c_write_master.sv =====
// ----------------------------------------------------------------------------
// amp_volume_i2c_write_master
// Turns volume, mute and raw register commands into I2C write frames,
// emitted as a stream of bus symbols (start, bits, ack slots, stop).
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  command  | in_valid_i/in_ready_o, action_i, ...       | in
//  symbols  | out_valid_o/out_ready_i, symbol_o, ...     | out
//  config   | cfg_we_i, cfg_wdata_i (device addr byte)   | in
//
//  Each accepted command, bar the unused code, gives 29 symbols at one per
//  cycle while the output is not stalled, from the single back-end serializer.
//  A two-entry frame queue lets commands be taken while a frame is sent.
//  A stalled output holds the current symbol; the serializer freezes.
//  Reset clears the volume word and restores the device address to 0xC0.
// ----------------------------------------------------------------------------
module amp_volume_i2c_write_master import avwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] volume_request_i,
  input  logic       mute_on_i,
  input  logic [7:0] reg_address_i,
  input  logic [7:0] reg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] symbol_o,
  output logic       sda_level_o,
  output logic       last_o
);

  logic [7:0] dev_addr_q;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  frame_t     q_frame;
  frame_t     q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  avwm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .volume_request_i (volume_request_i),
    .mute_on_i        (mute_on_i),
    .reg_address_i    (reg_address_i),
    .reg_data_i       (reg_data_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_frame_o        (q_frame)
  );

  avwm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_frame_i (q_frame),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  avwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dev_addr_i  (dev_addr_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .symbol_o    (symbol_o),
    .sda_level_o (sda_level_o),
    .last_o      (last_o)
  );

endmodule
